FILE: hw/rtl/icf_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the image convolution filter
// no dependencies

package icf_pkg;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 16;
  localparam int CIDX_W     = 8;
  localparam int RES_W      = 24;
  localparam int POS_W      = 10;
  localparam int TAG_W      = 5;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W      = 4;

  localparam logic [RES_W-1:0] SAT_POS     = 24'h7FFFFF;
  localparam logic [RES_W-1:0] SAT_NEG     = 24'h800000;
  localparam logic [RES_W:0]   SAT_NEG_MAG = 25'h0800000;
  localparam logic [RES_W:0]   SAT_POS_MAG = 25'h07FFFFF;

  typedef enum logic [1:0] {
    MODE_COEF  = 2'd0,
    MODE_PIXEL = 2'd1,
    MODE_FLUSH = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CFG_KERNEL_SIZE  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TAPS,
    ST_DRAIN,
    ST_ROUND
  } state_t;

  // one window tap travelling along the cell chain
  typedef struct packed {
    logic                     valid;
    logic [TAG_W-1:0]         row;
    logic [PIX_W-1:0]         pix;
    logic signed [COEF_W-1:0] coef;
  } tap_t;

endpackage

FILE: hw/rtl/icf_if.sv
`timescale 1ns / 1ps
// valid/ready channels of the image convolution filter
// depends on icf_pkg

interface icf_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         mode;
  logic [icf_pkg::PIX_W-1:0]          pixel_value;
  logic [icf_pkg::CIDX_W-1:0]         coef_index;
  logic signed [icf_pkg::COEF_W-1:0]  coef_value;

  modport source (output valid, mode, pixel_value, coef_index, coef_value, input ready);
  modport sink (input valid, mode, pixel_value, coef_index, coef_value, output ready);
endinterface

interface icf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [icf_pkg::RES_W-1:0]   filtered_value;
  logic [icf_pkg::POS_W-1:0]          out_row;
  logic [icf_pkg::POS_W-1:0]          out_col;
  logic                               out_last;
  logic                               frame_done;

  modport source (output valid, filtered_value, out_row, out_col, out_last, frame_done,
                  input ready);
  modport sink (input valid, filtered_value, out_row, out_col, out_last, frame_done,
                output ready);
endinterface

FILE: hw/rtl/icf_ram.sv
`timescale 1ns / 1ps
// generic simple dual port ram, one write port, one registered read port
// no dependencies

module icf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/icf_cell.sv
`timescale 1ns / 1ps
// one cell of the accumulation chain: owns one kernel row
// depends on icf_pkg

module icf_cell #(
  parameter int CELL_ID = 0,
  parameter int ACC_W   = 34
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clear,
  input  icf_pkg::tap_t           tap_in,
  input  logic signed [ACC_W-1:0] sum_in,
  output icf_pkg::tap_t           tap_out,
  output logic signed [ACC_W-1:0] sum_out
);
  import icf_pkg::*;

  logic signed [PIX_W+COEF_W:0] product;
  logic signed [ACC_W-1:0]      acc;
  logic                         mine;

  assign mine    = tap_in.valid && (tap_in.row == TAG_W'(CELL_ID));
  assign product = $signed({1'b0, tap_in.pix}) * tap_in.coef;

  // tap moves on to the neighbor every cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_out.valid <= 1'b0;
    end else begin
      tap_out.valid <= tap_in.valid;
    end
    tap_out.row  <= tap_in.row;
    tap_out.pix  <= tap_in.pix;
    tap_out.coef <= tap_in.coef;
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (mine) begin
      acc <= acc + ACC_W'(product);
    end
    sum_out <= sum_in + acc;
  end

endmodule

FILE: hw/rtl/image_convolution_filter_unit.sv
`timescale 1ns / 1ps
// top level of the k x k image convolution filter
// depends on icf_pkg, icf_if, icf_ram, icf_cell

// Usage
// item channel: mode 0 writes one kernel coefficient, mode 1 one pixel in raster
// order, mode 2 is a flush step, mode 3 does nothing. result channel: one transfer
// per output pixel, at most 8 per item, out_last on the last one of an item.
// Registers kernel_size, image_width, image_height sit on the apb port at 0, 4, 8;
// a write restarts the frame. Write them only while the block is idle.
// Sequence: a coefficient or unused item is taken in idle and the block stays idle.
// A pixel or flush item goes to a check of the output register; then, per result,
// K*K taps (one line store read each) run down the cell chain, the partial sums
// drain down the chain and the result is rounded. The single read port of the line
// store sets the tap rate.
// Reset clears positions and registers (K=3, 1024 x 1024); kernel and line stores
// are not cleared and must be written before use. There is no clearing pass.
// A stalled receiver holds the output register; the block waits until it drains
// before the next result and takes no new item until the current one is done.

module image_convolution_filter_unit #(
  parameter int MAX_KERNEL     = 15,
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_HEIGHT     = 1024,
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  icf_in_if.sink                           item,
  icf_out_if.source                        result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [icf_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [icf_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [icf_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import icf_pkg::*;

  localparam int KW       = $clog2(MAX_KERNEL + 1);
  localparam int LINE_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int KDEPTH   = MAX_KERNEL * MAX_KERNEL;
  localparam int KADDR_W  = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
  localparam int LDEPTH   = MAX_KERNEL * MAX_WIDTH;
  localparam int LADDR_W  = $clog2(LDEPTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W    = $clog2(MAX_WIDTH + 1);
  localparam int RR_W     = ROW_W + 2;
  localparam int CC_W     = COL_W + 2;
  localparam int ACC_W    = 26 + KADDR_W;
  localparam int DRAIN_CYCLES = 2 * MAX_KERNEL + 3;
  localparam int DRAIN_W  = $clog2(DRAIN_CYCLES + 1);
  localparam int RND_HALF = 1 << (COEF_FRAC_BITS - 1);

  // configuration registers
  logic [3:0]  kernel_size;
  logic [10:0] image_width;
  logic [10:0] image_height;
  logic        cfg_write;
  cfg_reg_t    cfg_sel;

  // effective sizes
  logic [KW-1:0]    k_eff;
  logic [COL_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [KW:0]      k_inc;
  logic [KW-1:0]    back;
  logic [KW-1:0]    half;

  // frame positions
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [LINE_W-1:0] in_line;
  logic [ROW_W-1:0]  emit_row;
  logic [COL_W-1:0]  emit_col;
  logic [LINE_W-1:0] emit_line;
  logic [CNT_W-1:0]  res_cnt;
  logic              stop_flag;

  // tap sequencer
  logic [KW-1:0]            tap_i;
  logic [KW-1:0]            tap_j;
  logic [KADDR_W-1:0]       tap_kaddr;
  logic signed [RR_W-1:0]   tap_rraw;
  logic signed [CC_W-1:0]   tap_craw;
  logic signed [CC_W-1:0]   tap_craw0;
  logic [LINE_W-1:0]        tap_line;
  logic                     row_ok;
  logic                     col_ok;
  logic [COL_W-1:0]         tap_cc;
  logic                     rd_valid;
  logic [TAG_W-1:0]         rd_row;
  logic [DRAIN_W-1:0]       drain_cnt;

  // pending result and output register
  logic                    pend_valid;
  logic signed [RES_W-1:0] pend_value;
  logic [POS_W-1:0]        pend_row;
  logic [POS_W-1:0]        pend_col;
  logic                    pend_done;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   px_write;
  logic   k_write;
  logic   cont;
  logic   ready_pos;
  logic   done_pos;
  logic   out_free;
  logic   out_load;
  logic   go;
  logic   acc_clear;

  logic [ROW_W:0] nr_raw;
  logic [ROW_W:0] nr;
  logic [COL_W:0] nc_raw;
  logic [COL_W:0] nc;

  // memories
  logic [LADDR_W-1:0]       l_waddr;
  logic [LADDR_W-1:0]       l_raddr;
  logic [PIX_W-1:0]         l_rdata;
  logic [KADDR_W-1:0]       k_waddr;
  logic [COEF_W-1:0]        k_rdata;

  // chain links
  tap_t                    tap_link [MAX_KERNEL+1];
  logic signed [ACC_W-1:0] sum_link [MAX_KERNEL+1];

  // rounding
  logic signed [ACC_W-1:0] total;
  logic                    neg;
  logic [ACC_W-1:0]        mag;
  logic [ACC_W:0]          rnd_sum;
  logic [ACC_W:0]          quot;
  logic [RES_W-1:0]        rounded;

  // ---------------------------------------------------------------
  // apb configuration port
  // ---------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_sel   = cfg_reg_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready &&
                     ((cfg_sel == CFG_KERNEL_SIZE) || (cfg_sel == CFG_IMAGE_WIDTH) ||
                      (cfg_sel == CFG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_size  <= 4'd3;
      image_width  <= 11'd1024;
      image_height <= 11'd1024;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_sel)
        CFG_KERNEL_SIZE:  kernel_size  <= pwdata[3:0];
        CFG_IMAGE_WIDTH:  image_width  <= pwdata[10:0];
        CFG_IMAGE_HEIGHT: image_height <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      CFG_KERNEL_SIZE:  prdata = CFG_DATA_W'(kernel_size);
      CFG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(image_width);
      CFG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  // saturate sizes to what the stores hold
  assign k_eff = (kernel_size > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kernel_size);
  assign w_eff = (image_width == 11'd0) ? COL_W'(1) :
                 (image_width > MAX_WIDTH) ? COL_W'(MAX_WIDTH) : COL_W'(image_width);
  assign h_eff = (image_height == 11'd0) ? ROW_W'(1) :
                 (image_height > MAX_HEIGHT) ? ROW_W'(MAX_HEIGHT) : ROW_W'(image_height);
  assign k_inc = {1'b0, k_eff} + (KW+1)'(1);
  // window starts ceil(k/2)-1 back, reaches floor(k/2) ahead
  assign back  = k_inc[KW:1] - KW'(1);
  assign half  = k_eff >> 1;

  // ---------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------
  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign k_write    = accept && (mode_t'(item.mode) == MODE_COEF) &&
                      (32'(item.coef_index) < KDEPTH);
  assign px_write   = accept && (mode_t'(item.mode) == MODE_PIXEL) &&
                      (in_row < h_eff) && (in_col < w_eff);
  assign k_waddr    = KADDR_W'(item.coef_index);
  assign l_waddr    = LADDR_W'(32'(in_line) * MAX_WIDTH + 32'(in_col));

  // ---------------------------------------------------------------
  // readiness of the next output
  // ---------------------------------------------------------------
  assign nr_raw = {1'b0, emit_row} + (ROW_W+1)'(half);
  assign nr     = (nr_raw > {1'b0, h_eff - ROW_W'(1)}) ? {1'b0, h_eff - ROW_W'(1)} : nr_raw;
  assign nc_raw = {1'b0, emit_col} + (COL_W+1)'(half);
  assign nc     = (nc_raw > {1'b0, w_eff - COL_W'(1)}) ? {1'b0, w_eff - COL_W'(1)} : nc_raw;

  // raster compare instead of row * width
  assign ready_pos = (in_row >= h_eff) ||
                     ({1'b0, in_row} > nr) ||
                     (({1'b0, in_row} == nr) && ({1'b0, in_col} > nc));
  assign cont      = (res_cnt < CNT_W'(MAX_RESULTS)) && !stop_flag &&
                     (emit_row < h_eff) && ready_pos;
  assign done_pos  = (emit_row == h_eff - ROW_W'(1)) && (emit_col == w_eff - COL_W'(1));
  assign out_free  = !result.valid || result.ready;

  // ---------------------------------------------------------------
  // control
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    go         = 1'b0;
    acc_clear  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && ((mode_t'(item.mode) == MODE_PIXEL) ||
                       (mode_t'(item.mode) == MODE_FLUSH))) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // a finished result waits here for the output register
        if (!pend_valid || out_free) begin
          out_load = pend_valid;
          if (cont) begin
            go         = 1'b1;
            acc_clear  = 1'b1;
            state_next = (k_eff == '0) ? ST_DRAIN : ST_TAPS;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_TAPS: begin
        if ((tap_i == k_eff - KW'(1)) && (tap_j == k_eff - KW'(1))) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt == '0) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_next = ST_CHECK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // positions, counters and pending result
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      in_row    <= '0;
      in_col    <= '0;
      in_line   <= '0;
      emit_row  <= '0;
      emit_col  <= '0;
      emit_line <= '0;
      res_cnt   <= '0;
      stop_flag <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (accept) begin
        res_cnt   <= '0;
        stop_flag <= 1'b0;
      end
      if (px_write) begin
        if (in_col + COL_W'(1) >= w_eff) begin
          in_col  <= '0;
          in_row  <= in_row + ROW_W'(1);
          in_line <= (in_line == LINE_W'(MAX_KERNEL - 1)) ? '0 : in_line + LINE_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end
      if (out_load) begin
        pend_valid <= 1'b0;
      end
      if (state == ST_ROUND) begin
        pend_valid <= 1'b1;
        res_cnt    <= res_cnt + CNT_W'(1);
        if (done_pos) begin
          // frame complete: everything restarts
          stop_flag <= 1'b1;
          in_row    <= '0;
          in_col    <= '0;
          in_line   <= '0;
          emit_row  <= '0;
          emit_col  <= '0;
          emit_line <= '0;
        end else if (emit_col + COL_W'(1) >= w_eff) begin
          emit_col  <= '0;
          emit_row  <= emit_row + ROW_W'(1);
          emit_line <= (emit_line == LINE_W'(MAX_KERNEL - 1)) ? '0 :
                       emit_line + LINE_W'(1);
        end else begin
          emit_col <= emit_col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ROUND) begin
      pend_value <= rounded;
      pend_row   <= POS_W'(emit_row);
      pend_col   <= POS_W'(emit_col);
      pend_done  <= done_pos;
    end
  end

  // ---------------------------------------------------------------
  // tap sequencer: kernel row i outer, column j inner
  // ---------------------------------------------------------------
  assign row_ok = tap_rraw[RR_W-1] || ($unsigned(tap_rraw[ROW_W:0]) < {1'b0, h_eff});
  assign col_ok = tap_craw[CC_W-1] || ($unsigned(tap_craw[COL_W:0]) < {1'b0, w_eff});
  assign tap_cc = tap_craw[CC_W-1] ? '0 : tap_craw[COL_W-1:0];
  assign l_raddr = (row_ok && col_ok) ?
                   LADDR_W'(32'(tap_line) * MAX_WIDTH + 32'(tap_cc)) : '0;

  always_ff @(posedge clk) begin
    if (go) begin
      tap_i     <= '0;
      tap_j     <= '0;
      tap_kaddr <= '0;
      tap_rraw  <= RR_W'(emit_row) - RR_W'(back);
      tap_craw  <= CC_W'(emit_col) - CC_W'(back);
      tap_craw0 <= CC_W'(emit_col) - CC_W'(back);
      // rows above the image clamp to row 0, which sits in line 0
      if (emit_row < ROW_W'(back)) begin
        tap_line <= '0;
      end else if (emit_line >= LINE_W'(back)) begin
        tap_line <= emit_line - LINE_W'(back);
      end else begin
        tap_line <= LINE_W'(32'(emit_line) + MAX_KERNEL - 32'(back));
      end
    end else if (state == ST_TAPS) begin
      tap_kaddr <= tap_kaddr + KADDR_W'(1);
      if (tap_j == k_eff - KW'(1)) begin
        tap_j    <= '0;
        tap_i    <= tap_i + KW'(1);
        tap_craw <= tap_craw0;
        tap_rraw <= tap_rraw + RR_W'(1);
        if (!tap_rraw[RR_W-1]) begin
          tap_line <= (tap_line == LINE_W'(MAX_KERNEL - 1)) ? '0 : tap_line + LINE_W'(1);
        end
      end else begin
        tap_j    <= tap_j + KW'(1);
        tap_craw <= tap_craw + CC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_TAPS) && row_ok && col_ok;
    end
    rd_row <= TAG_W'(tap_i);
  end

  always_ff @(posedge clk) begin
    if (rst || go) begin
      drain_cnt <= DRAIN_W'(DRAIN_CYCLES);
    end else if ((state == ST_DRAIN) && (drain_cnt != '0)) begin
      drain_cnt <= drain_cnt - DRAIN_W'(1);
    end
  end

  // ---------------------------------------------------------------
  // stores
  // ---------------------------------------------------------------
  icf_ram #(.WIDTH(COEF_W), .DEPTH(KDEPTH)) u_kernel_store (
    .clk   (clk),
    .we    (k_write),
    .waddr (k_waddr),
    .wdata (item.coef_value),
    .raddr (tap_kaddr),
    .rdata (k_rdata)
  );

  icf_ram #(.WIDTH(PIX_W), .DEPTH(LDEPTH)) u_line_store (
    .clk   (clk),
    .we    (px_write),
    .waddr (l_waddr),
    .wdata (item.pixel_value),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  // ---------------------------------------------------------------
  // cell chain: taps ripple right, each cell sums its kernel row,
  // partial sums ripple right as well
  // ---------------------------------------------------------------
  assign tap_link[0].valid = rd_valid;
  assign tap_link[0].row   = rd_row;
  assign tap_link[0].pix   = l_rdata;
  assign tap_link[0].coef  = $signed(k_rdata);
  assign sum_link[0]       = '0;

  for (genvar g = 0; g < MAX_KERNEL; g++) begin : g_cell
    icf_cell #(.CELL_ID(g), .ACC_W(ACC_W)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (acc_clear),
      .tap_in  (tap_link[g]),
      .sum_in  (sum_link[g]),
      .tap_out (tap_link[g+1]),
      .sum_out (sum_link[g+1])
    );
  end

  // ---------------------------------------------------------------
  // round half away from zero, saturate to 24 bits
  // ---------------------------------------------------------------
  assign total   = sum_link[MAX_KERNEL];
  assign neg     = total[ACC_W-1];
  assign mag     = neg ? $unsigned(-total) : $unsigned(total);
  assign rnd_sum = {1'b0, mag} + (ACC_W+1)'(RND_HALF);
  assign quot    = rnd_sum >> COEF_FRAC_BITS;

  always_comb begin
    if (neg) begin
      rounded = (quot > (ACC_W+1)'(SAT_NEG_MAG)) ? SAT_NEG : RES_W'(-quot);
    end else begin
      rounded = (quot > (ACC_W+1)'(SAT_POS_MAG)) ? SAT_POS : RES_W'(quot);
    end
  end

  // ---------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.filtered_value <= pend_value;
      result.out_row        <= pend_row;
      result.out_col        <= pend_col;
      result.frame_done     <= pend_done;
      result.out_last       <= !cont;
    end
  end

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("pending result left behind on return to idle");

  a_result_bound: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= CNT_W'(MAX_RESULTS))
    else $error("more results than allowed for one transfer");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.frame_done) |-> result.out_last)
    else $error("frame end not marked as last result");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("output register overwritten before transfer");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> (emit_col < w_eff))
    else $error("emit column past row end");

endmodule
